// ----- design/sequence_store_extreme_removal_core_defines.svh -----
// Assertion macros shared by the checker of the sequence store core.
`ifndef SEQUENCE_STORE_EXTREME_REMOVAL_CORE_DEFINES_SVH
`define SEQUENCE_STORE_EXTREME_REMOVAL_CORE_DEFINES_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define SSES_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define SSES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/sses_pkg.sv -----
// Types, constants and codes for the sequence store core.
package sses_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_idx IDX_LAST = t_idx'(CAPACITY - 1);
    localparam t_cnt CNT_FULL = t_cnt'(CAPACITY);

    localparam logic [2:0] OP_APPEND     = 3'd0;
    localparam logic [2:0] OP_DROP_MAX   = 3'd1;
    localparam logic [2:0] OP_DROP_MIN   = 3'd2;
    localparam logic [2:0] OP_DROP_ALL_MAX = 3'd3;
    localparam logic [2:0] OP_DROP_ALL_MIN = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;
    localparam logic [2:0] OP_DUMP       = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
        logic [4:0]               entry_count;
        logic                     last;
    } t_out;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_WRITE,
        CELL_COMPACT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] key;
        t_idx                     idx;
        t_cnt                     count;
        logic                     all;
    } t_cell_ctl;

endpackage

// ----- design/sses_cell.sv -----
// One storage cell of the chain: holds one entry and shifts toward the head.
module sses_cell (
    input  logic                               i_clk,
    input  sses_pkg::t_cell_ctl                i_ctl,
    input  sses_pkg::t_idx                     i_index,
    input  logic signed [sses_pkg::DATA_W-1:0] i_next,
    input  logic                               i_hit,
    output logic signed [sses_pkg::DATA_W-1:0] o_val,
    output logic                               o_hit
);

    logic signed [sses_pkg::DATA_W-1:0] r_val;
    logic signed [sses_pkg::DATA_W-1:0] n_val;
    logic                               w_match;

    always_comb begin
        w_match = 1'b0;
        if (i_ctl.op == sses_pkg::CELL_COMPACT) begin
            if (i_ctl.all) begin
                w_match = (r_val == i_ctl.key) &&
                          (sses_pkg::t_cnt'(i_index) < i_ctl.count);
            end else begin
                w_match = (i_index == i_ctl.idx);
            end
        end
    end

    assign o_hit = i_hit | w_match;
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            sses_pkg::CELL_ROTATE: n_val = i_next;
            sses_pkg::CELL_WRITE: begin
                if (i_index == i_ctl.idx) begin
                    n_val = i_ctl.data;
                end
            end
            sses_pkg::CELL_COMPACT: begin
                if (o_hit) begin
                    n_val = i_next;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ----- design/sses_chain.sv -----
// Row of storage cells with the head entry and a match flag at the far end.
module sses_chain (
    input  logic                               i_clk,
    input  sses_pkg::t_cell_ctl                i_ctl,
    output logic signed [sses_pkg::DATA_W-1:0] o_head,
    output logic                               o_any
);

    logic signed [sses_pkg::DATA_W-1:0] w_val [sses_pkg::CAPACITY];
    logic                               w_hit [sses_pkg::CAPACITY+1];

    assign w_hit[0] = 1'b0;

    for (genvar k = 0; k < sses_pkg::CAPACITY; k++) begin : g_cell
        logic signed [sses_pkg::DATA_W-1:0] w_next;
        if (k == sses_pkg::CAPACITY - 1) begin : g_tail
            assign w_next = w_val[0];
        end else begin : g_body
            assign w_next = w_val[k+1];
        end
        sses_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_index (sses_pkg::t_idx'(k)),
            .i_next  (w_next),
            .i_hit   (w_hit[k]),
            .o_val   (w_val[k]),
            .o_hit   (w_hit[k+1])
        );
    end

    assign o_head = w_val[0];
    assign o_any  = w_hit[sses_pkg::CAPACITY];

endmodule

// ----- design/sequence_store_extreme_removal_core.sv -----
// Top level of the sequence store: command sequencer around the cell chain.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------
//  command   | start, busy              | i_cmd    (sses_pkg::t_in)
//  result    | o_valid, one per result  | o_result (sses_pkg::t_out)
//
// Append, clear and any operation on an empty store: busy stays low, result next cycle.
// Drop first max/min: one rotation of the chain to scan, then one shift.
// Drop all max/min: one rotation of the chain to scan, then one shift of the chain per match.
// Dump: one rotation of the chain, one result per stored entry.
// Reset empties the store; the result side cannot stall, results are never held.
module sequence_store_extreme_removal_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sses_pkg::t_in  i_cmd,
    output logic           o_valid,
    output sses_pkg::t_out o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE,
        S_DUMP
    } t_state;

    t_state                             r_state, n_state;
    sses_pkg::t_cnt                     r_n, n_n;
    sses_pkg::t_idx                     r_i, n_i;
    logic signed [sses_pkg::DATA_W-1:0] r_best, n_best;
    sses_pkg::t_idx                     r_bidx, n_bidx;
    logic                               r_max, n_max;
    logic                               r_all, n_all;
    logic                               r_valid, n_valid;
    sses_pkg::t_out                     r_out, n_out;

    sses_pkg::t_cell_ctl                w_ctl;
    logic signed [sses_pkg::DATA_W-1:0] w_head;
    logic                               w_any;
    logic                               w_better;
    sses_pkg::t_cnt                     w_n_dec;

    sses_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head),
        .o_any  (w_any)
    );

    assign w_better = r_max ? (w_head > r_best) : (w_head < r_best);
    assign w_n_dec  = r_n - 1'b1;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_best  = r_best;
        n_bidx  = r_bidx;
        n_max   = r_max;
        n_all   = r_all;
        n_valid = 1'b0;
        n_out   = r_out;

        w_ctl.op    = sses_pkg::CELL_HOLD;
        w_ctl.data  = i_cmd.value;
        w_ctl.key   = r_best;
        w_ctl.idx   = (r_state == S_REMOVE) ? r_bidx : sses_pkg::t_idx'(r_n);
        w_ctl.count = r_n;
        w_ctl.all   = r_all;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.operation)
                        sses_pkg::OP_APPEND: begin
                            n_valid = 1'b1;
                            if (r_n >= sses_pkg::CNT_FULL) begin
                                n_out = '{i_cmd.value, sses_pkg::ST_FULL, 5'(r_n), 1'b1};
                            end else begin
                                w_ctl.op = sses_pkg::CELL_WRITE;
                                n_n      = r_n + 1'b1;
                                n_out    = '{i_cmd.value, sses_pkg::ST_OK,
                                             5'(r_n + 1'b1), 1'b1};
                            end
                        end
                        sses_pkg::OP_DROP_MAX, sses_pkg::OP_DROP_MIN,
                        sses_pkg::OP_DROP_ALL_MAX, sses_pkg::OP_DROP_ALL_MIN: begin
                            if (r_n == '0) begin
                                n_valid = 1'b1;
                                n_out   = '{'0, sses_pkg::ST_EMPTY, 5'd0, 1'b1};
                            end else begin
                                n_max   = (i_cmd.operation == sses_pkg::OP_DROP_MAX) ||
                                          (i_cmd.operation == sses_pkg::OP_DROP_ALL_MAX);
                                n_all   = (i_cmd.operation == sses_pkg::OP_DROP_ALL_MAX) ||
                                          (i_cmd.operation == sses_pkg::OP_DROP_ALL_MIN);
                                n_i     = '0;
                                n_state = S_SCAN;
                            end
                        end
                        sses_pkg::OP_CLEAR: begin
                            n_n     = '0;
                            n_valid = 1'b1;
                            n_out   = '{'0, sses_pkg::ST_OK, 5'd0, 1'b1};
                        end
                        sses_pkg::OP_DUMP: begin
                            if (r_n == '0) begin
                                n_valid = 1'b1;
                                n_out   = '{'0, sses_pkg::ST_EMPTY, 5'd0, 1'b1};
                            end else begin
                                n_i     = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                w_ctl.op = sses_pkg::CELL_ROTATE;
                if (r_i == '0) begin
                    n_best = w_head;
                    n_bidx = '0;
                end else if ((sses_pkg::t_cnt'(r_i) < r_n) && w_better) begin
                    n_best = w_head;
                    n_bidx = r_i;
                end
                n_i = r_i + 1'b1;
                if (r_i == sses_pkg::IDX_LAST) begin
                    n_state = S_REMOVE;
                end
            end
            S_REMOVE: begin
                w_ctl.op = sses_pkg::CELL_COMPACT;
                if (r_all) begin
                    if (w_any) begin
                        n_n = w_n_dec;
                    end else begin
                        n_valid = 1'b1;
                        n_out   = '{r_best, sses_pkg::ST_OK, 5'(r_n), 1'b1};
                        n_state = S_IDLE;
                    end
                end else begin
                    n_n     = w_n_dec;
                    n_valid = 1'b1;
                    n_out   = '{r_best, sses_pkg::ST_OK, 5'(w_n_dec), 1'b1};
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                w_ctl.op = sses_pkg::CELL_ROTATE;
                if (sses_pkg::t_cnt'(r_i) < r_n) begin
                    n_valid = 1'b1;
                    n_out   = '{w_head, sses_pkg::ST_OK, 5'(r_n),
                                sses_pkg::t_cnt'(r_i) == w_n_dec};
                end
                n_i = r_i + 1'b1;
                if (r_i == sses_pkg::IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_best <= n_best;
        r_bidx <= n_bidx;
        r_max  <= n_max;
        r_all  <= n_all;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_valid <= n_valid;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ----- design/sses_checker.sv -----
// Port-level checker for the sequence store core and its bind.
`include "sequence_store_extreme_removal_core_defines.svh"

module sses_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input sses_pkg::t_in  i_cmd,
    input logic           o_valid,
    input sses_pkg::t_out o_result
);

    `SSES_ASSERT_SAME(a_full_count, o_valid && (o_result.status == sses_pkg::ST_FULL), o_result.entry_count == 5'(sses_pkg::CAPACITY), "full status without a full store")
    `SSES_ASSERT_SAME(a_empty_result, o_valid && (o_result.status == sses_pkg::ST_EMPTY), (o_result.entry_count == 5'd0) && (o_result.result_value == '0) && o_result.last, "malformed empty result")
    `SSES_ASSERT_NEXT(a_clear_done, start && !busy && (i_cmd.operation == sses_pkg::OP_CLEAR), o_valid && (o_result.entry_count == 5'd0) && o_result.last, "clear transaction gave no empty result")
    `SSES_ASSERT_SAME(a_dump_busy, o_valid && !o_result.last, busy, "transaction ended before its last result")

endmodule

bind sequence_store_extreme_removal_core sses_checker u_checker (.*);

// ----- verif/sses_store_checker.sv -----
`timescale 1ns / 1ps
// Checker for the sequence store core: predicts every result and compares it.
module sses_store_checker
    import sses_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_cmd,
    input  logic i_valid,
    input  t_out i_result,
    output int   o_fail_count,
    output int   o_pending
);

    logic signed [DATA_W-1:0] store_model [CAPACITY];
    int                       fill_model;
    t_out                     expected_results [$];
    int                       shown;

    initial begin
        fill_model   = 0;
        shown        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void note_result(logic signed [DATA_W-1:0] v, logic [1:0] st,
                                        logic lst);
        t_out r;
        r.result_value = v;
        r.status       = st;
        r.entry_count  = 5'(fill_model);
        r.last         = lst;
        expected_results.push_back(r);
    endfunction

    function automatic int extreme_index(bit want_max);
        int best;
        best = 0;
        for (int i = 1; i < fill_model; i++) begin
            if (want_max ? (store_model[i] > store_model[best])
                         : (store_model[i] < store_model[best]))
                best = i;
        end
        return best;
    endfunction

    task automatic predict_command(input t_in cmd);
        int                       idx;
        int                       kept;
        logic signed [DATA_W-1:0] ext;
        case (cmd.operation)
            OP_APPEND: begin
                if (fill_model >= CAPACITY) begin
                    note_result(cmd.value, ST_FULL, 1'b1);
                end else begin
                    store_model[fill_model] = cmd.value;
                    fill_model++;
                    note_result(cmd.value, ST_OK, 1'b1);
                end
            end
            OP_DROP_MAX, OP_DROP_MIN: begin
                if (fill_model == 0) begin
                    note_result('0, ST_EMPTY, 1'b1);
                end else begin
                    idx = extreme_index(cmd.operation == OP_DROP_MAX);
                    ext = store_model[idx];
                    for (int i = idx; i + 1 < fill_model; i++)
                        store_model[i] = store_model[i+1];
                    fill_model--;
                    note_result(ext, ST_OK, 1'b1);
                end
            end
            OP_DROP_ALL_MAX, OP_DROP_ALL_MIN: begin
                if (fill_model == 0) begin
                    note_result('0, ST_EMPTY, 1'b1);
                end else begin
                    ext  = store_model[extreme_index(cmd.operation == OP_DROP_ALL_MAX)];
                    kept = 0;
                    for (int i = 0; i < fill_model; i++) begin
                        if (store_model[i] != ext) begin
                            store_model[kept] = store_model[i];
                            kept++;
                        end
                    end
                    fill_model = kept;
                    note_result(ext, ST_OK, 1'b1);
                end
            end
            OP_CLEAR: begin
                fill_model = 0;
                note_result('0, ST_OK, 1'b1);
            end
            OP_DUMP: begin
                if (fill_model == 0) begin
                    note_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < fill_model; i++)
                        note_result(store_model[i], ST_OK, i + 1 == fill_model);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out exp_r;
        bit   bad;
        if (!i_rst_n) begin
            fill_model = 0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("checker: unexpected result value=%0d status=%0d count=%0d last=%0b",
                                 i_result.result_value, i_result.status,
                                 i_result.entry_count, i_result.last);
                    end
                end else begin
                    exp_r = expected_results.pop_front();
                    bad   = (i_result.result_value !== exp_r.result_value)
                          || (i_result.status !== exp_r.status)
                          || (i_result.entry_count !== exp_r.entry_count)
                          || (i_result.last !== exp_r.last);
                    if (bad) begin
                        o_fail_count++;
                        if (shown < 10) begin
                            shown++;
                            $display("checker: mismatch exp value=%0d status=%0d count=%0d last=%0b",
                                     exp_r.result_value, exp_r.status, exp_r.entry_count,
                                     exp_r.last);
                            $display("checker:          got value=%0d status=%0d count=%0d last=%0b",
                                     i_result.result_value, i_result.status,
                                     i_result.entry_count, i_result.last);
                        end
                    end
                end
            end
            if (i_start && !i_busy)
                predict_command(i_cmd);
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the sequence store core: clock, reset, stimulus and verdict.
module tb;
    import sses_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int         LIMIT     = 100000;
    localparam int         RANDOM_N  = 155;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  cmd_bus;
    logic o_valid;
    t_out o_result;
    int   fail_count;
    int   pending;
    int   cycles;

    sequence_store_extreme_removal_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd_bus),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    sses_store_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd_bus),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic issue(input logic [2:0] op, input logic signed [DATA_W-1:0] v);
        @(negedge i_clk);
        start             <= 1'b1;
        cmd_bus.operation <= op;
        cmd_bus.value     <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value;
        logic signed [DATA_W-1:0] edges [4];
        edges = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, -32'sd1};
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return edges[$urandom_range(0, 3)];
            default: return $signed($urandom_range(0, 7)) - 3;
        endcase
    endfunction

    initial begin
        logic signed [DATA_W-1:0] fill_vals [16];
        logic [2:0]               drop_ops [4];
        int                       weights [3];
        int                       sent;
        int                       r;
        logic [2:0]               op;
        bit                       quiet;

        fill_vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1,
                      32'sh7FFFFFFF, 32'sh80000000, 32'sd5, 32'sd5, 32'shAAAAAAAA,
                      32'sh55555555, -32'sd3, 32'sh7FFFFFFF, 32'sh80000000, 32'sd2,
                      32'sh0};
        drop_ops  = '{OP_DROP_MAX, OP_DROP_MIN, OP_DROP_ALL_MAX, OP_DROP_ALL_MIN};
        weights   = '{40, 70, 90};

        i_rst_n = 1'b0;
        start   = 1'b0;
        cmd_bus = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(OP_DUMP, 32'sh0);
        issue(OP_DROP_ALL_MIN, 32'sh0);
        issue(OP_UNUSED, -32'sd1);
        foreach (fill_vals[i])
            issue(OP_APPEND, fill_vals[i]);
        issue(OP_APPEND, 32'sh12345678);
        issue(OP_DUMP, 32'sh0);
        issue(OP_DROP_MAX, 32'sh0);
        issue(OP_DROP_MIN, 32'sh0);
        issue(OP_DROP_ALL_MAX, 32'sh0);
        issue(OP_CLEAR, 32'sh0);
        drain();

        sent = 0;
        while (sent < RANDOM_N) begin
            quiet = (sent >= 60) && (sent < 110);
            if (!quiet && $urandom_range(0, 99) < 12)
                hold_off($urandom_range(1, 4));
            if (sent == 90)
                drain();
            r = $urandom_range(0, 99);
            if (r < weights[(sent / 30) % 3]) begin
                op = OP_APPEND;
            end else begin
                r = $urandom_range(0, 19);
                if (r < 14)
                    op = drop_ops[r % 4];
                else if (r == 14)
                    op = OP_CLEAR;
                else if (r < 19)
                    op = OP_DUMP;
                else
                    op = OP_UNUSED;
            end
            issue(op, pick_value());
            if (op != OP_UNUSED)
                sent++;
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- sequence_store_extreme_removal_core.f -----
+incdir+design
design/sses_pkg.sv
design/sses_cell.sv
design/sses_chain.sv
design/sequence_store_extreme_removal_core.sv
design/sses_checker.sv
verif/sses_store_checker.sv
verif/tb.sv
